>>> rtl/sle_pkg.sv
// Shared definitions for the sorted list engine: field widths, command and
// status codes, and the compare result type.
// No dependencies.
package sle_pkg;

  // Payload field widths.
  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 6;

  // Default list capacity.
  localparam int DEF_CAPACITY = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  // Result of the shared comparator.
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

>>> rtl/sle_if.sv
// Valid/ready channel interfaces for the command input and the result output.
// Depends on sle_pkg for the field widths.
interface sle_in_if;
  import sle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sle_out_if;
  import sle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] entry;
  logic [ST_W-1:0]          status;
  logic [OCC_W-1:0]         occupancy;
  logic                     last;

  modport source (output valid, output entry, output status, output occupancy,
                  output last, input ready);
  modport sink   (input valid, input entry, input status, input occupancy,
                  input last, output ready);
endinterface

>>> rtl/sle_mem.sv
// Entry storage for the sorted list: one write port and one registered read port.
// Depends on sle_pkg for the data width.
module sle_mem #(
  parameter int DEPTH = sle_pkg::DEF_CAPACITY,
  parameter int IDX_W = $clog2(sle_pkg::DEF_CAPACITY)
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [IDX_W-1:0]                 wr_addr,
  input  logic signed [sle_pkg::DATA_W-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [IDX_W-1:0]                 rd_addr,
  output logic signed [sle_pkg::DATA_W-1:0] rd_data
);
  import sle_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/sle_cmp.sv
// Shared signed comparator used by both the insert and the remove walks.
// Depends on sle_pkg for the data width and the result type.
module sle_cmp (
  input  logic signed [sle_pkg::DATA_W-1:0] a,
  input  logic signed [sle_pkg::DATA_W-1:0] b,
  output sle_pkg::cmp_res_t                 res
);
  import sle_pkg::*;

  // Greater-than decides where an insert stops; equality finds a remove target.
  always_comb begin
    res.gt = (a > b);
    res.eq = (a == b);
  end

endmodule

>>> rtl/sorted_list_engine.sv
// Sorted list engine top level: command sequencer, entry storage and comparator.
// Depends on sle_pkg, sle_if, sle_mem and sle_cmp.
//
// Holds up to CAPACITY signed 32-bit values in ascending order. The block takes
// one command at a time and is not ready until that command is finished and its
// last result is in the output register. The entries live in a memory with a
// registered read port that is never read and written in the same cycle, so
// every step of a walk over the list is a read state followed by an evaluate
// state that compares and writes. An insert walks down from the top past the
// entries greater than the new value, a remove walks the whole list, and a
// read-out emits one result per entry; a clear or an insert into a full list
// goes straight to its result. While the output register still holds a result
// that is not taken, the sequencer waits in its final step. The output register
// lets a new command start while the final result of the previous one still
// waits to be taken. An empty read-out produces no result.
module sorted_list_engine #(
  parameter int CAPACITY = sle_pkg::DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  sle_in_if.sink    in_ch,
  sle_out_if.source out_ch
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EV   = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  // Control state.
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload state.
  logic [CMD_W-1:0]         cmd_r, cmd_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] pend_entry_r, pend_entry_nxt;
  logic [ST_W-1:0]          pend_status_r, pend_status_nxt;
  logic                     pend_last_r, pend_last_nxt;
  logic signed [DATA_W-1:0] out_entry_r;
  logic [ST_W-1:0]          out_status_r;
  logic [OCC_W-1:0]         out_occ_r;
  logic                     out_last_r;

  // Memory and comparator connections.
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [IDX_W-1:0]         mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;
  cmp_res_t                 cmp_res;

  logic [CNT_W-1:0] idx_dec;
  logic [CNT_W-1:0] idx_inc;
  logic             out_load;
  logic             out_free;
  logic             in_xfer;

  sle_mem #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  sle_cmp u_cmp (
    .a   (mem_rdata),
    .b   (val_r),
    .res (cmp_res)
  );

  assign idx_dec  = idx_r - CNT_ONE;
  assign idx_inc  = idx_r + CNT_ONE;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.entry     = out_entry_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.occupancy = out_occ_r;
  assign out_ch.last      = out_last_r;

  // Sequencer: walks the list one entry per read/evaluate pair.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    found_nxt       = found_r;
    cmd_nxt         = cmd_r;
    val_nxt         = val_r;
    pend_entry_nxt  = pend_entry_r;
    pend_status_nxt = pend_status_r;
    pend_last_nxt   = pend_last_r;
    mem_we          = 1'b0;
    mem_waddr       = idx_r[IDX_W-1:0];
    mem_wdata       = val_r;
    mem_re          = 1'b0;
    mem_raddr       = idx_r[IDX_W-1:0];
    out_load        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt         = in_ch.cmd;
          val_nxt         = in_ch.value;
          pend_entry_nxt  = '0;
          pend_status_nxt = ST_OK;
          pend_last_nxt   = 1'b1;
          found_nxt       = 1'b0;
          idx_nxt         = '0;
          case (in_ch.cmd)
            CMD_INSERT: begin
              if (cnt_r == CNT_FULL) begin
                pend_status_nxt = ST_FULL;
                state_nxt       = S_EMIT;
              end else begin
                // Walk downward from the top, moving larger entries up by one.
                idx_nxt   = cnt_r;
                state_nxt = S_RD;
              end
            end
            CMD_REMOVE: begin
              state_nxt = S_RD;
            end
            CMD_READ: begin
              if (cnt_r != '0) begin
                state_nxt = S_RD;
              end
            end
            default: begin
              cnt_nxt   = '0;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end

      S_RD: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (idx_r == '0) begin
              mem_we    = 1'b1;
              cnt_nxt   = cnt_r + CNT_ONE;
              state_nxt = S_EMIT;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = idx_dec[IDX_W-1:0];
              state_nxt = S_EV;
            end
          end
          CMD_REMOVE: begin
            if (idx_r == cnt_r) begin
              if (found_r) begin
                cnt_nxt = cnt_r - CNT_ONE;
              end else begin
                pend_status_nxt = ST_NOT_FOUND;
              end
              state_nxt = S_EMIT;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_EV;
            end
          end
          CMD_READ: begin
            mem_re    = 1'b1;
            state_nxt = S_EV;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_EV: begin
        case (cmd_r)
          CMD_INSERT: begin
            mem_we = 1'b1;
            if (cmp_res.gt) begin
              // Larger entry moves up one place.
              mem_wdata = mem_rdata;
              idx_nxt   = idx_dec;
              state_nxt = S_RD;
            end else begin
              // New value goes after all entries not greater than it.
              cnt_nxt   = cnt_r + CNT_ONE;
              state_nxt = S_EMIT;
            end
          end
          CMD_REMOVE: begin
            // Once the first match is seen, later entries move down one place.
            if (found_r) begin
              mem_we    = 1'b1;
              mem_waddr = idx_dec[IDX_W-1:0];
              mem_wdata = mem_rdata;
            end else if (cmp_res.eq) begin
              found_nxt = 1'b1;
            end
            idx_nxt   = idx_inc;
            state_nxt = S_RD;
          end
          CMD_READ: begin
            pend_entry_nxt = mem_rdata;
            pend_last_nxt  = (idx_inc == cnt_r);
            state_nxt      = S_EMIT;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (cmd_r == CMD_READ && !pend_last_r) begin
            idx_nxt   = idx_inc;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    val_r         <= val_nxt;
    pend_entry_r  <= pend_entry_nxt;
    pend_status_r <= pend_status_nxt;
    pend_last_r   <= pend_last_nxt;
    if (out_load) begin
      out_entry_r  <= pend_entry_r;
      out_status_r <= pend_status_r;
      out_occ_r    <= OCC_W'(cnt_r);
      out_last_r   <= pend_last_r;
    end
  end

  // The count never exceeds the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("list count above capacity");

  // A clear empties the list on the next cycle.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.cmd == CMD_CLEAR) |=> (cnt_r == '0))
    else $error("clear did not empty the list");

  // An insert into a full list leaves the count unchanged.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.cmd == CMD_INSERT && cnt_r == CNT_FULL)
      |=> (cnt_r == CNT_FULL && state_r == S_EMIT))
    else $error("insert into full list changed the list");

  // The memory is only written during an insert or remove walk.
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == S_RD || state_r == S_EV)
                && (cmd_r == CMD_INSERT || cmd_r == CMD_REMOVE)))
    else $error("memory write outside an insert or remove");

endmodule

>>> test/testbench.sv
// Self-checking testbench for the sorted list engine: directed and random command
// streams with random idling on both channels, checked against a behavioral list.
// Depends on sle_pkg, sle_if and sorted_list_engine from the rtl folder.
package sorted_list_check_pkg;
  import sle_pkg::*;

  localparam int LIST_DEPTH = DEF_CAPACITY;

  // One result transfer as the block should produce it.
  typedef struct {
    logic signed [DATA_W-1:0] entry;
    logic [ST_W-1:0]          status;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;
  } list_result_t;

  // Tracks the list contents and the results each accepted command should cause.
  class sorted_list_tracker;
    logic signed [DATA_W-1:0] held[$];
    list_result_t             due_results[$];
    int errors;
    int results_checked;
    int inserts, full_refusals, removes, misses, readouts, clears, deepest;

    function void queue_result(logic signed [DATA_W-1:0] entry, logic [ST_W-1:0] status,
                               logic last);
      list_result_t r;
      r.entry     = entry;
      r.status    = status;
      r.occupancy = OCC_W'(held.size());
      r.last      = last;
      due_results.push_back(r);
    endfunction

    // Apply one accepted command to the list and queue the results it causes.
    function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
      int pos;
      pos = 0;
      case (cmd)
        CMD_INSERT: begin
          inserts++;
          if (held.size() >= LIST_DEPTH) begin
            full_refusals++;
            queue_result('0, ST_FULL, 1'b1);
          end else begin
            // A new value goes after every entry equal to it.
            while (pos < held.size() && held[pos] <= value) pos++;
            held.insert(pos, value);
            if (held.size() > deepest) deepest = held.size();
            queue_result('0, ST_OK, 1'b1);
          end
        end
        CMD_REMOVE: begin
          removes++;
          while (pos < held.size() && held[pos] != value) pos++;
          if (pos >= held.size()) begin
            misses++;
            queue_result('0, ST_NOT_FOUND, 1'b1);
          end else begin
            held.delete(pos);
            queue_result('0, ST_OK, 1'b1);
          end
        end
        CMD_READ: begin
          // An empty list streams nothing.
          readouts++;
          foreach (held[i]) queue_result(held[i], ST_OK, i == held.size() - 1);
        end
        default: begin
          clears++;
          held.delete();
          queue_result('0, ST_OK, 1'b1);
        end
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function bit field_ok(string name, logic signed [DATA_W-1:0] want, got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Compare one result transfer with the oldest outstanding expectation.
    function void check_result(logic signed [DATA_W-1:0] entry, logic [ST_W-1:0] status,
                               logic [OCC_W-1:0] occupancy, logic last);
      list_result_t want;
      bit ok;
      results_checked++;
      if (due_results.size() == 0) begin
        $display({"%0t: result with nothing outstanding, expected none, ",
                  "actual entry %0d status %0d occupancy %0d last %0d"},
                 $time, entry, status, occupancy, last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      ok = field_ok("entry", want.entry, entry);
      ok &= field_ok("status", DATA_W'(want.status), DATA_W'(status));
      ok &= field_ok("occupancy", DATA_W'(want.occupancy), DATA_W'(occupancy));
      ok &= field_ok("last", DATA_W'(want.last), DATA_W'(last));
      if (!ok) errors++;
    endfunction
  endclass
endpackage

module testbench;
  import sle_pkg::*;
  import sorted_list_check_pkg::*;

  localparam int      DIRECTED_MAX    = 25;
  localparam int      RANDOM_ITEMS    = 346;
  localparam int      LONG_HOLD       = 300;
  localparam int      HOLD_AFTER      = 60;
  localparam int      SETTLE_CYCLES   = 200;
  localparam longint  TIMEOUT_CYCLES  = 3_000_000;
  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

  typedef enum int {ROUND_FILL, ROUND_MIXED, ROUND_DRAIN, ROUND_WIPE} round_kind_t;

  logic clk;
  logic rst_n;
  bit   steady;
  bit   long_hold_done;
  int   commands_sent;

  sorted_list_tracker tracker;

  sle_in_if  in_ch();
  sle_out_if out_ch();

  sorted_list_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock with a period of 4.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hang guard.
  initial begin
    #(TIMEOUT_CYCLES * 4);
    $display("Test completed with failures");
    $finish;
  end

  // Gap length for the sender: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (steady || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Operand mix: full range, a narrow band that makes duplicates, extremes,
  // and values already in the list so that removes hit.
  function automatic logic signed [DATA_W-1:0] pick_value(bit favor_held);
    int r;
    r = $urandom_range(0, 9);
    if (tracker.held.size() > 0 && (r >= 7 || (favor_held && r >= 2)))
      return tracker.held[$urandom_range(0, tracker.held.size() - 1)];
    if (r < 3) return $urandom;
    if (r < 6) return int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 3))
      0:       return MAX_VAL;
      1:       return MIN_VAL;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Offer one command after a random gap and hold it until the transfer.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_command(cmd, value);
    commands_sent++;
  endtask

  task automatic run_round(round_kind_t kind);
    int n;
    int r;
    case (kind)
      ROUND_FILL: begin
        // Fill to capacity, then push a few inserts into the full list.
        while (tracker.held.size() < LIST_DEPTH) send_command(CMD_INSERT, pick_value(1'b0));
        repeat ($urandom_range(1, 3)) send_command(CMD_INSERT, pick_value(1'b0));
        send_command(CMD_READ, $urandom);
      end
      ROUND_DRAIN: begin
        while (tracker.held.size() > 0) begin
          if ($urandom_range(0, 7) == 0) send_command(CMD_REMOVE, $urandom);
          else send_command(CMD_REMOVE, pick_value(1'b1));
        end
        send_command(CMD_REMOVE, pick_value(1'b0));
        send_command(CMD_READ, $urandom);
      end
      ROUND_WIPE: begin
        send_command(CMD_READ, $urandom);
        send_command(CMD_CLEAR, $urandom);
      end
      default: begin
        n = $urandom_range(10, 30);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 48) send_command(CMD_INSERT, pick_value(1'b0));
          else if (r < 80) send_command(CMD_REMOVE, pick_value(1'b1));
          else if (r < 96) send_command(CMD_READ, $urandom);
          else send_command(CMD_CLEAR, $urandom);
        end
      end
    endcase
  endtask

  // Result side: check every transfer and choose the next ready level.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        tracker.check_result(out_ch.entry, out_ch.status, out_ch.occupancy, out_ch.last);
      // One long hold-off so the block backs up and stalls its input.
      if (!long_hold_done && tracker.results_checked >= HOLD_AFTER) begin
        stall_left     = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 13) begin
          out_ch.ready <= 1'b1;
        end else begin
          stall_left = (r < 19) ? $urandom_range(0, 2) : $urandom_range(14, 39);
          out_ch.ready <= 1'b0;
        end
      end
    end
  end

  // Reset, directed commands, random rounds, then drain and report.
  initial begin
    round_kind_t kind;
    int          round_no;
    tracker        = new();
    steady         = 1'b0;
    long_hold_done = 1'b0;
    commands_sent  = 0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_INSERT;
    in_ch.value    <= '0;
    out_ch.ready   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: read-out gives nothing, remove misses.
    send_command(CMD_READ, '0);
    send_command(CMD_REMOVE, 32'sd7);
    // Extremes and duplicates; the signed order puts the minimum first.
    send_command(CMD_INSERT, '0);
    send_command(CMD_INSERT, MAX_VAL);
    send_command(CMD_INSERT, MIN_VAL);
    send_command(CMD_INSERT, '1);
    send_command(CMD_INSERT, 32'sd1);
    send_command(CMD_INSERT, '0);
    send_command(CMD_INSERT, MAX_VAL);
    send_command(CMD_READ, 32'sh1234_5678);
    // Remove the first of two equal entries, an absent value, head and tail.
    send_command(CMD_REMOVE, '0);
    send_command(CMD_REMOVE, 32'sd5);
    send_command(CMD_REMOVE, MIN_VAL);
    send_command(CMD_REMOVE, MAX_VAL);
    send_command(CMD_READ, '1);
    // Clear with a nonzero operand, then an empty read-out.
    send_command(CMD_CLEAR, '1);
    send_command(CMD_READ, MIN_VAL);
    send_command(CMD_INSERT, 32'sh5555_5555);
    send_command(CMD_INSERT, 32'shAAAA_AAAA);
    send_command(CMD_READ, MAX_VAL);
    send_command(CMD_REMOVE, 32'sh5555_5555);
    send_command(CMD_REMOVE, 32'shAAAA_AAAA);
    send_command(CMD_REMOVE, 32'shAAAA_AAAA);
    send_command(CMD_CLEAR, '0);

    // Random rounds; the first one always fills the list.
    round_no = 0;
    while (commands_sent < DIRECTED_MAX + RANDOM_ITEMS) begin
      steady = (round_no > 0) && ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1:    kind = ROUND_FILL;
        2:       kind = ROUND_DRAIN;
        3:       kind = ROUND_WIPE;
        default: kind = ROUND_MIXED;
      endcase
      if (round_no == 0) kind = ROUND_FILL;
      run_round(kind);
      round_no++;
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display({"Sent %0d commands: %0d inserts (%0d into a full list), ",
              "%0d removes (%0d misses), %0d read-outs, %0d clears."},
             commands_sent, tracker.inserts, tracker.full_refusals, tracker.removes,
             tracker.misses, tracker.readouts, tracker.clears);
    $display("Checked %0d results; the list held up to %0d entries; output hold-off %s.",
             tracker.results_checked, tracker.deepest,
             long_hold_done ? "applied" : "not reached");
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
